// ===== src/rtab_pkg.sv =====
// ----------------------------------------------------------------------------
// rtab_pkg
// Types and codes shared by the rule table controller, datapath and top level.
// ----------------------------------------------------------------------------
package rtab_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_UPSERT = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [63:0]        source_key;
		logic signed [31:0] method_key;
		logic signed [31:0] new_priority;
		logic               permit_external_aux;
		logic               permit_builtin_aux;
		logic [3:0]         rank;
		logic               used_exact;
		logic               used_auxiliary;
	} in_item_t;

	typedef struct packed {
		logic               ok;
		logic [4:0]         rule_count;
		logic [63:0]        out_source;
		logic signed [31:0] out_method;
		logic signed [31:0] out_priority;
		logic               out_permit_external;
		logic               out_permit_builtin;
		logic               anchored;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_SEARCH,
		S_PLACE,
		S_UP,
		S_DN,
		S_WRE,
		S_RDW,
		S_FIN
	} state_t;

	typedef struct packed {
		logic cap;
		logic do_clear;
		logic rd_rank;
		logic rd_first;
		logic srch_next;
		logic hit_take;
		logic append;
		logic up_start;
		logic up_move;
		logic dn_start;
		logic dn_move;
		logic wr_e;
		logic res_ok;
		logic res_read;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       meth_zero;
		logic       empty;
		logic       rank_ok;
		logic       match;
		logic       more;
		logic       room;
		logic       pos_top;
		logic       pos_last;
		logic       pos_le1;
		logic       dn_end;
		logic       e_before_rd;
		logic       rd_before_e;
		logic       moved;
		logic       out_busy;
	} sts_t;

endpackage

// ===== src/rtab_ram.sv =====
// ----------------------------------------------------------------------------
// rtab_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module rtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/rtab_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtab_ctrl
// Sequencer for the rule table: decode, key search, insertion shifts, result.
// ----------------------------------------------------------------------------
module rtab_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rtab_pkg::sts_t sts,
	output rtab_pkg::cmd_t cmd
);
	import rtab_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DEC;
			end
			S_DEC: begin
				unique case (sts.op)
					OP_CLEAR: state_d = S_FIN;
					OP_READ: state_d = sts.rank_ok ? S_RDW : S_FIN;
					OP_UPSERT: begin
						if (sts.meth_zero) state_d = S_FIN;
						else if (sts.empty) state_d = S_PLACE;
						else state_d = S_SEARCH;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SEARCH: begin
				if (sts.match) state_d = S_PLACE;
				else if (sts.more) state_d = S_SEARCH;
				else if (sts.room) state_d = S_PLACE;
				else state_d = S_FIN;
			end
			S_PLACE: begin
				if (!sts.pos_top) state_d = S_UP;
				else if (!sts.pos_last) state_d = S_DN;
				else state_d = S_WRE;
			end
			S_UP: begin
				if (sts.e_before_rd) state_d = sts.pos_le1 ? S_WRE : S_UP;
				else if (sts.moved) state_d = S_WRE;
				else if (!sts.pos_last) state_d = S_DN;
				else state_d = S_WRE;
			end
			S_DN: begin
				if (sts.rd_before_e) state_d = sts.dn_end ? S_WRE : S_DN;
				else state_d = S_WRE;
			end
			S_WRE: state_d = S_FIN;
			S_RDW: state_d = S_FIN;
			S_FIN: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.cap = req_valid;
			S_DEC: begin
				unique case (sts.op)
					OP_CLEAR: begin
						cmd.do_clear = 1'b1;
						cmd.res_ok = 1'b1;
					end
					OP_READ: cmd.rd_rank = sts.rank_ok;
					OP_UPSERT: begin
						if (!sts.meth_zero) begin
							cmd.append = sts.empty;
							cmd.rd_first = !sts.empty;
						end
					end
					default: cmd = '0;
				endcase
			end
			S_SEARCH: begin
				if (sts.match) cmd.hit_take = 1'b1;
				else if (sts.more) cmd.srch_next = 1'b1;
				else if (sts.room) cmd.append = 1'b1;
			end
			S_PLACE: begin
				if (!sts.pos_top) cmd.up_start = 1'b1;
				else if (!sts.pos_last) cmd.dn_start = 1'b1;
			end
			S_UP: begin
				if (sts.e_before_rd) cmd.up_move = 1'b1;
				else if (!sts.moved && !sts.pos_last) cmd.dn_start = 1'b1;
			end
			S_DN: cmd.dn_move = sts.rd_before_e;
			S_WRE: begin
				cmd.wr_e = 1'b1;
				cmd.res_ok = 1'b1;
			end
			S_RDW: cmd.res_read = 1'b1;
			S_FIN: cmd.res_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/rtab_dp.sv =====
// ----------------------------------------------------------------------------
// rtab_dp
// Rule table datapath: entry memory, count, working pointers and result beat.
// ----------------------------------------------------------------------------
module rtab_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rtab_pkg::in_item_t  req,
	input  rtab_pkg::cmd_t      cmd,
	output rtab_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rtab_pkg::out_item_t rsp
);
	import rtab_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = CW + 5;
	localparam int EW = 64 + 32 + 32 + IW + 2;

	in_item_t           item_q;
	out_item_t          res_q;
	out_item_t          rsp_q;
	out_item_t          rsp_d;
	logic               rsp_valid_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      ord_q;
	logic               moved_q;

	logic               we;
	logic [IW-1:0]      waddr;
	logic [EW-1:0]      wdata;
	logic [IW-1:0]      raddr;
	logic [EW-1:0]      rdata;

	logic [63:0]        rd_src;
	logic signed [31:0] rd_meth;
	logic signed [31:0] rd_prio;
	logic [IW-1:0]      rd_ord;
	logic [1:0]         rd_flags;
	logic [1:0]         e_flags;
	logic [EW-1:0]      e_word;
	logic [RW-1:0]      cnt_x;
	logic [RW-1:0]      pos_x;
	logic [RW-1:0]      idx_x;
	logic               prio_eq;

	rtab_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_src   = rdata[EW-1 -: 64];
	assign rd_meth  = rdata[EW-65 -: 32];
	assign rd_prio  = rdata[EW-97 -: 32];
	assign rd_ord   = rdata[IW+1:2];
	assign rd_flags = rdata[1:0];
	assign e_flags  = {item_q.permit_builtin_aux, item_q.permit_external_aux};
	assign e_word   = {item_q.source_key, item_q.method_key, item_q.new_priority,
		ord_q, e_flags};
	assign cnt_x    = RW'(count_q);
	assign pos_x    = RW'(pos_q);
	assign idx_x    = RW'(idx_q);
	assign prio_eq  = (item_q.new_priority == rd_prio);

	always_comb begin
		sts.op          = item_q.op;
		sts.meth_zero   = (item_q.method_key == 32'sd0);
		sts.empty       = (count_q == '0);
		sts.rank_ok     = (RW'(item_q.rank) < cnt_x);
		sts.match       = (rd_src == item_q.source_key) && (rd_meth == item_q.method_key);
		sts.more        = ((idx_x + RW'(1)) < cnt_x);
		sts.room        = (cnt_x < RW'(TABLE_DEPTH));
		sts.pos_top     = (pos_q == '0);
		sts.pos_last    = ((pos_x + RW'(1)) >= cnt_x);
		sts.pos_le1     = (pos_x <= RW'(1));
		sts.dn_end      = ((pos_x + RW'(2)) >= cnt_x);
		sts.e_before_rd = (item_q.new_priority > rd_prio) || (prio_eq && (ord_q < rd_ord));
		sts.rd_before_e = (rd_prio > item_q.new_priority) || (prio_eq && (rd_ord < ord_q));
		sts.moved       = moved_q;
		sts.out_busy    = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		raddr = '0;
		if (cmd.rd_rank) raddr = IW'(item_q.rank);
		else if (cmd.srch_next) raddr = idx_q + IW'(1);
		else if (cmd.up_start) raddr = pos_q - IW'(1);
		else if (cmd.up_move) raddr = pos_q - IW'(2);
		else if (cmd.dn_start) raddr = pos_q + IW'(1);
		else if (cmd.dn_move) raddr = pos_q + IW'(2);
		we    = cmd.up_move || cmd.dn_move || cmd.wr_e;
		waddr = pos_q;
		wdata = cmd.wr_e ? e_word : rdata;
	end

	always_comb begin
		rsp_d            = res_q;
		rsp_d.rule_count = 5'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			moved_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.do_clear) count_q <= '0;
			else if (cmd.append) count_q <= count_q + CW'(1);
			if (cmd.up_start) moved_q <= 1'b0;
			else if (cmd.up_move) moved_q <= 1'b1;
			if (cmd.res_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= req;
			res_q  <= '0;
		end
		if (cmd.res_ok) res_q.ok <= 1'b1;
		if (cmd.res_read) begin
			res_q.ok                  <= 1'b1;
			res_q.out_source          <= rd_src;
			res_q.out_method          <= rd_meth;
			res_q.out_priority        <= rd_prio;
			res_q.out_permit_external <= rd_flags[0];
			res_q.out_permit_builtin  <= rd_flags[1];
			res_q.anchored            <= (rd_flags == 2'b00) || !item_q.used_auxiliary ||
				item_q.used_exact;
		end
		if (cmd.rd_first) idx_q <= '0;
		else if (cmd.srch_next) idx_q <= idx_q + IW'(1);
		if (cmd.hit_take) begin
			pos_q <= idx_q;
			ord_q <= rd_ord;
		end else if (cmd.append) begin
			pos_q <= IW'(count_q);
			ord_q <= IW'(count_q);
		end else if (cmd.up_move) begin
			pos_q <= pos_q - IW'(1);
		end else if (cmd.dn_move) begin
			pos_q <= pos_q + IW'(1);
		end
		if (cmd.res_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		RW'(count_q) <= RW'(TABLE_DEPTH))
		else $error("Rule count exceeds the table depth.");
	a_write_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_e |-> pos_x < cnt_x)
		else $error("Rule written outside the filled part of the table.");
	a_up_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.up_move |-> pos_q != '0)
		else $error("Upward shift from the top rank.");
	a_dn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dn_move |-> (pos_x + RW'(1)) < cnt_x)
		else $error("Downward shift past the last rule.");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.up_move, cmd.dn_move, cmd.wr_e}))
		else $error("Conflicting table writes in one cycle.");

endmodule

// ===== src/priority_ordered_rule_table_unit.sv =====
// ----------------------------------------------------------------------------
// priority_ordered_rule_table_unit
// Bounded rule table kept sorted by priority, with upsert, clear and ranked read.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time and returns one response beat for
// each. A clear, an undefined op and an upsert with method zero go from the
// decode state straight to the finishing state, as does a read of a rank that
// holds no rule; any other read passes through a read-wait state. An upsert
// that finds no match in a full table scans every entry before it finishes.
// Any other upsert searches its key among the stored rules unless the table is
// empty (one entry per cycle through the entry RAM read port), then compares
// the rule with its neighbours and shifts it into its rank (one shift per
// cycle) and writes it. A finished response waits in an output register, and
// the next request is taken once that register can accept it, so a stalled
// response holds the block in its finishing state until it is taken.
module priority_ordered_rule_table_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rtab_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rtab_pkg::out_item_t rsp
);
	import rtab_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rtab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtab_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
